// ===== src/fac_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, types and stage enables for the frustum box cull test
package fac_pkg;

    localparam int PLANE_COUNT = 6;
    localparam int COORD_BITS  = 16;
    localparam int REG_COUNT   = 6;
    localparam int REG_W       = 64;
    localparam int COEF_W      = 16;
    localparam int IDX_W       = 3;
    localparam int D_SHIFT     = 8;
    localparam int PROD_W      = COORD_BITS + COEF_W;
    localparam int SUM_W       = PROD_W + 2;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [COEF_W-1:0]     t_coef;
    typedef logic signed [PROD_W-1:0]     t_prod;
    typedef logic signed [SUM_W-1:0]      t_sum;
    typedef logic [REG_W-1:0]             t_plane;
    typedef logic [IDX_W-1:0]             t_idx;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_pipe_en;

endpackage

// ===== src/fac_box_if.sv =====
`timescale 1ns / 1ps
// box input channel: valid, ready and the two box corners
interface fac_box_if import fac_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord min_x;
    t_coord min_y;
    t_coord min_z;
    t_coord max_x;
    t_coord max_y;
    t_coord max_z;

    modport source (output valid, min_x, min_y, min_z, max_x, max_y, max_z, input ready);
    modport sink   (input valid, min_x, min_y, min_z, max_x, max_y, max_z, output ready);
endinterface

// ===== src/fac_vis_if.sv =====
`timescale 1ns / 1ps
// result channel: valid, ready and the visible flag
interface fac_vis_if import fac_pkg::*; ();
    logic valid;
    logic ready;
    logic visible;

    modport source (output valid, visible, input ready);
    modport sink   (input valid, visible, output ready);
endinterface

// ===== src/frustum_aabb_cull_test.sv =====
`timescale 1ns / 1ps
// top level: frustum cull test of axis-aligned boxes against the plane set
//
//   channel   direction  carries
//   i_box     in         min_x min_y min_z max_x max_y max_z (Q8.8)
//   o_vis     out        visible
//   i_cfg_*   in         plane register writes, index 0..5
//
// one box per cycle while o_vis is ready; five register stages, the
// last of which drives o_vis valid and visible
// stages: products, axis maximum, partial sums, sign, plane reduction
// each stage holds only while the stage after it is full and held, so
// bubbles close up and a stalled output still lets upstream stages fill
// synchronous active-low reset clears valid bits and plane registers
module frustum_aabb_cull_test import fac_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fac_box_if.sink       i_box,
    fac_vis_if.source     o_vis,
    input  logic          i_cfg_we,
    input  t_idx          i_cfg_idx,
    input  t_plane        i_cfg_data
);

    t_plane   planes [PLANE_COUNT];
    t_pipe_en en;
    logic     en_out;
    logic [PLANE_COUNT-1:0] outside;

    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic r_vis;

    fac_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_planes   (planes)
    );

    assign en_out = !r_v5 || o_vis.ready;
    assign en.s4  = !r_v4 || en_out;
    assign en.s3  = !r_v3 || en.s4;
    assign en.s2  = !r_v2 || en.s3;
    assign en.s1  = !r_v1 || en.s2;

    assign i_box.ready = en.s1;

    for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_lane
        fac_plane u_plane (
            .i_clk     (i_clk),
            .i_en      (en),
            .i_plane   (planes[p]),
            .i_min_x   (i_box.min_x),
            .i_min_y   (i_box.min_y),
            .i_min_z   (i_box.min_z),
            .i_max_x   (i_box.max_x),
            .i_max_y   (i_box.max_y),
            .i_max_z   (i_box.max_z),
            .o_outside (outside[p])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en.s1) begin
                r_v1 <= i_box.valid;
            end
            if (en.s2) begin
                r_v2 <= r_v1;
            end
            if (en.s3) begin
                r_v3 <= r_v2;
            end
            if (en.s4) begin
                r_v4 <= r_v3;
            end
            if (en_out) begin
                r_v5 <= r_v4;
            end
        end
    end

    // culled when any plane has every corner strictly outside
    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_vis <= ~|outside;
        end
    end

    assign o_vis.valid   = r_v5;
    assign o_vis.visible = r_vis;

endmodule

// ===== src/fac_regs.sv =====
`timescale 1ns / 1ps
// plane coefficient registers behind the configuration write port
module fac_regs import fac_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_cfg_we,
    input  t_idx   i_cfg_idx,
    input  t_plane i_cfg_data,
    output t_plane o_planes [PLANE_COUNT]
);

    for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
        if (p < REG_COUNT) begin : g_reg
            t_plane r_plane;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_plane <= '0;
                end else if (i_cfg_we && i_cfg_idx == IDX_W'(p)) begin
                    r_plane <= i_cfg_data;
                end
            end

            assign o_planes[p] = r_plane;
        end else begin : g_none
            // slots without a register never cull
            assign o_planes[p] = '0;
        end
    end

endmodule

// ===== src/fac_plane.sv =====
`timescale 1ns / 1ps
// one plane lane: products, per-axis maximum, sum and sign in four stages
module fac_plane import fac_pkg::*; (
    input  logic     i_clk,
    input  t_pipe_en i_en,
    input  t_plane   i_plane,
    input  t_coord   i_min_x,
    input  t_coord   i_min_y,
    input  t_coord   i_min_z,
    input  t_coord   i_max_x,
    input  t_coord   i_max_y,
    input  t_coord   i_max_z,
    output logic     o_outside
);

    t_coef coef_a;
    t_coef coef_b;
    t_coef coef_c;
    t_coef coef_d;

    t_prod r_pxl, r_pxh, r_pyl, r_pyh, r_pzl, r_pzh;
    t_prod r_mx, r_my, r_mz;
    t_sum  r_sxy, r_szd;
    logic  r_out;

    t_prod n_mx, n_my, n_mz;
    t_sum  n_dot;

    assign coef_a = i_plane[COEF_W-1:0];
    assign coef_b = i_plane[2*COEF_W-1:COEF_W];
    assign coef_c = i_plane[3*COEF_W-1:2*COEF_W];
    assign coef_d = i_plane[4*COEF_W-1:3*COEF_W];

    // products for both corner values of each axis
    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_pxl <= PROD_W'(coef_a) * PROD_W'(i_min_x);
            r_pxh <= PROD_W'(coef_a) * PROD_W'(i_max_x);
            r_pyl <= PROD_W'(coef_b) * PROD_W'(i_min_y);
            r_pyh <= PROD_W'(coef_b) * PROD_W'(i_max_y);
            r_pzl <= PROD_W'(coef_c) * PROD_W'(i_min_z);
            r_pzh <= PROD_W'(coef_c) * PROD_W'(i_max_z);
        end
    end

    // the corner with the largest dot product decides the plane
    always_comb begin
        n_mx = (r_pxh > r_pxl) ? r_pxh : r_pxl;
        n_my = (r_pyh > r_pyl) ? r_pyh : r_pyl;
        n_mz = (r_pzh > r_pzl) ? r_pzh : r_pzl;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_mx <= n_mx;
            r_my <= n_my;
            r_mz <= n_mz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_sxy <= SUM_W'(r_mx) + SUM_W'(r_my);
            r_szd <= SUM_W'(r_mz) + (SUM_W'(coef_d) <<< D_SHIFT);
        end
    end

    assign n_dot = r_sxy + r_szd;

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_out <= n_dot[SUM_W-1];
        end
    end

    assign o_outside = r_out;

endmodule

// ===== dv/tb_frustum_aabb_cull_test.sv =====
`timescale 1ns / 1ps
// testbench for the frustum box cull test: plane sets, box streams, visible flag checks
module tb_frustum_aabb_cull_test;
    import fac_pkg::*;

    localparam t_idx IDX_LEFT    = 3'd0;
    localparam t_idx IDX_RIGHT   = 3'd1;
    localparam t_idx IDX_TOP     = 3'd2;
    localparam t_idx IDX_BOTTOM  = 3'd3;
    localparam t_idx IDX_NEAR    = 3'd4;
    localparam t_idx IDX_FAR     = 3'd5;
    localparam t_idx IDX_SPARE_A = 3'd6;
    localparam t_idx IDX_SPARE_B = 3'd7;

    localparam t_coef Q412_ONE   = 16'sh1000;
    localparam t_coef Q412_MAX   = 16'sh7fff;
    localparam t_coef Q412_MIN   = 16'sh8000;
    localparam int    PIPE_LAT   = 5;
    localparam int    ITEM_GOAL  = 700;
    localparam int    CALM_FROM  = 580;
    localparam time   LIMIT_NS   = 2_000_000;

    typedef struct {
        t_coord min_x;
        t_coord min_y;
        t_coord min_z;
        t_coord max_x;
        t_coord max_y;
        t_coord max_z;
    } t_box_item;

    class cull_scoreboard;
        t_plane planes[REG_COUNT];
        bit     vis_queue[$];
        int     errors;
        int     noted;

        function new();
            foreach (planes[i]) planes[i] = '0;
            errors = 0;
            noted  = 0;
        endfunction

        function void load_plane(t_idx idx, t_plane val);
            if (idx < REG_COUNT) planes[idx] = val;
        endfunction

        function bit box_visible(t_box_item b);
            longint lo[3];
            longint hi[3];
            longint cf[4];
            longint x, y, z, dot;
            t_coef  raw;
            bit     all_out;
            lo[0] = b.min_x; lo[1] = b.min_y; lo[2] = b.min_z;
            hi[0] = b.max_x; hi[1] = b.max_y; hi[2] = b.max_z;
            for (int p = 0; p < PLANE_COUNT; p++) begin
                if (p >= REG_COUNT) continue;
                for (int k = 0; k < 4; k++) begin
                    raw   = planes[p][COEF_W*k +: COEF_W];
                    cf[k] = raw;
                end
                all_out = 1'b1;
                for (int corner = 0; corner < 8; corner++) begin
                    x   = corner[2] ? hi[0] : lo[0];
                    y   = corner[1] ? hi[1] : lo[1];
                    z   = corner[0] ? hi[2] : lo[2];
                    dot = cf[0] * x + cf[1] * y + cf[2] * z + (cf[3] <<< D_SHIFT);
                    if (dot >= 0) all_out = 1'b0;
                end
                if (all_out) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_box(t_box_item b);
            vis_queue.push_back(box_visible(b));
            noted++;
        endfunction

        function void check_vis(logic vis);
            bit want;
            if (vis_queue.size() == 0) begin
                $display("%0t: unexpected result, expected none actual visible=%b", $time, vis);
                errors++;
                return;
            end
            want = vis_queue.pop_front();
            if (vis !== want) begin
                $display("%0t: visible mismatch, expected %b actual %b", $time, want, vis);
                errors++;
            end
        endfunction

        function int pending();
            return vis_queue.size();
        endfunction
    endclass

    logic   i_clk;
    logic   i_rst_n;
    logic   cfg_we;
    t_idx   cfg_idx;
    t_plane cfg_data;

    fac_box_if box_if ();
    fac_vis_if vis_if ();

    frustum_aabb_cull_test i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_box      (box_if),
        .o_vis      (vis_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    cull_scoreboard sb = new();
    bit     bursts_on;
    int     stall_left;
    int     sent;
    t_plane plane_set[REG_COUNT];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_NS);
        $display("%0t: timeout with %0d results outstanding", $time, sb.pending());
        $display("tb_frustum_aabb_cull_test NOT OK");
        $finish;
    end

    // output stall bursts
    always @(posedge i_clk) begin
        if (stall_left > 1) begin
            stall_left   <= stall_left - 1;
            vis_if.ready <= 1'b0;
        end else if (stall_left == 1) begin
            stall_left   <= 0;
            vis_if.ready <= 1'b1;
        end else if (bursts_on && $urandom_range(0, 7) == 0) begin
            stall_left   <= $urandom_range(1, 18);
            vis_if.ready <= 1'b0;
        end else begin
            vis_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && box_if.valid && box_if.ready) begin
            sb.note_box('{box_if.min_x, box_if.min_y, box_if.min_z,
                          box_if.max_x, box_if.max_y, box_if.max_z});
        end
        if (i_rst_n && vis_if.valid && vis_if.ready) sb.check_vis(vis_if.visible);
    end

    function automatic t_coord clip_coord(int v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return t_coord'(v);
    endfunction

    function automatic t_box_item mk_box(int mnx, int mny, int mnz, int mxx, int mxy, int mxz);
        t_box_item b;
        b.min_x = t_coord'(mnx); b.min_y = t_coord'(mny); b.min_z = t_coord'(mnz);
        b.max_x = t_coord'(mxx); b.max_y = t_coord'(mxy); b.max_z = t_coord'(mxz);
        return b;
    endfunction

    function automatic t_plane pack_plane(t_coef a, t_coef b, t_coef c, t_coef d);
        return {d, c, b, a};
    endfunction

    function automatic t_plane rand_plane();
        t_coef cf[4];
        int    axis;
        case ($urandom_range(0, 3))
            0: return {$urandom, $urandom};
            1: return '0;
            default: begin
                axis = $urandom_range(0, 2);
                for (int k = 0; k < 3; k++)
                    cf[k] = t_coef'(int'($urandom_range(0, 511)) - 256);
                cf[axis] = $urandom_range(0, 1) ? Q412_ONE : -Q412_ONE;
                cf[3]    = t_coef'($urandom);
                return pack_plane(cf[0], cf[1], cf[2], cf[3]);
            end
        endcase
    endfunction

    function automatic t_box_item rand_box();
        t_box_item b;
        int        lo[3];
        int        hi[3];
        int        mid, half, kind;
        kind = $urandom_range(0, 9);
        if (kind < 2) begin
            b.min_x = t_coord'($urandom); b.min_y = t_coord'($urandom);
            b.min_z = t_coord'($urandom);
            b.max_x = t_coord'($urandom); b.max_y = t_coord'($urandom);
            b.max_z = t_coord'($urandom);
            return b;
        end
        for (int k = 0; k < 3; k++) begin
            mid  = (kind < 6) ? int'($urandom_range(0, 8191)) - 4096
                              : int'($urandom_range(0, 65535)) - 32768;
            half = (kind == 9) ? 0 : (kind < 8) ? $urandom_range(0, 2048)
                                                : $urandom_range(0, 32767);
            lo[k] = mid - half;
            hi[k] = mid + half;
        end
        b.min_x = clip_coord(lo[0]); b.min_y = clip_coord(lo[1]); b.min_z = clip_coord(lo[2]);
        b.max_x = clip_coord(hi[0]); b.max_y = clip_coord(hi[1]); b.max_z = clip_coord(hi[2]);
        return b;
    endfunction

    task automatic push_box(t_box_item b);
        if (bursts_on && $urandom_range(0, 4) == 0) begin
            box_if.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        box_if.valid <= 1'b1;
        box_if.min_x <= b.min_x;
        box_if.min_y <= b.min_y;
        box_if.min_z <= b.min_z;
        box_if.max_x <= b.max_x;
        box_if.max_y <= b.max_y;
        box_if.max_z <= b.max_z;
        do @(posedge i_clk); while (!box_if.ready);
        sent++;
    endtask

    task automatic drain();
        box_if.valid <= 1'b0;
        while (sb.pending() != 0 || sb.noted != sent) @(posedge i_clk);
        repeat (PIPE_LAT + 2) @(posedge i_clk);
    endtask

    // writes plane_set to all six planes, optionally hitting the unused indexes
    task automatic load_planes(bit spare);
        for (int i = 0; i < REG_COUNT; i++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= t_idx'(i);
            cfg_data <= plane_set[i];
            sb.load_plane(t_idx'(i), plane_set[i]);
            @(posedge i_clk);
        end
        if (spare) begin
            cfg_idx  <= IDX_SPARE_A;
            cfg_data <= {$urandom, $urandom};
            sb.load_plane(IDX_SPARE_A, '1);
            @(posedge i_clk);
            cfg_idx  <= IDX_SPARE_B;
            cfg_data <= '1;
            sb.load_plane(IDX_SPARE_B, '1);
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
    endtask

    initial begin
        int n_items;
        int live;
        i_rst_n      = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = IDX_LEFT;
        cfg_data     = '0;
        box_if.valid = 1'b0;
        box_if.min_x = '0; box_if.min_y = '0; box_if.min_z = '0;
        box_if.max_x = '0; box_if.max_y = '0; box_if.max_z = '0;
        vis_if.ready = 1'b1;
        stall_left   = 0;
        sent         = 0;
        bursts_on    = 1'b1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero planes after reset: everything visible, swapped corners too
        push_box(mk_box(-32768, -32768, -32768, -32768, -32768, -32768));
        push_box(mk_box(32767, 32767, 32767, 32767, 32767, 32767));
        push_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
        push_box(mk_box(32767, 32767, 32767, -32768, -32768, -32768));
        push_box(mk_box(0, 0, 0, 0, 0, 0));
        drain();

        // slab 0 <= x <= 1.0, spare indexes loaded with junk
        plane_set[IDX_LEFT]   = pack_plane(Q412_ONE, '0, '0, '0);
        plane_set[IDX_RIGHT]  = pack_plane(-Q412_ONE, '0, '0, Q412_ONE);
        plane_set[IDX_TOP]    = '0;
        plane_set[IDX_BOTTOM] = '0;
        plane_set[IDX_NEAR]   = '0;
        plane_set[IDX_FAR]    = '0;
        load_planes(1'b1);
        push_box(mk_box(-512, 0, 0, -1, 0, 0));
        push_box(mk_box(-512, -9, -9, 0, 9, 9));
        push_box(mk_box(0, 0, 0, 256, 0, 0));
        push_box(mk_box(256, 5, 5, 256, 5, 5));
        push_box(mk_box(257, 0, 0, 300, 0, 0));
        push_box(mk_box(100, 0, 0, -100, 0, 0));
        push_box(mk_box(-1, 0, 0, -200, 0, 0));
        push_box(mk_box(-32768, 0, 0, 32767, 0, 0));
        drain();

        // extreme coefficients in every position
        plane_set[IDX_LEFT]   = pack_plane(Q412_MIN, Q412_MIN, Q412_MIN, Q412_MIN);
        plane_set[IDX_RIGHT]  = pack_plane(Q412_MAX, Q412_MAX, Q412_MAX, Q412_MAX);
        plane_set[IDX_TOP]    = pack_plane('0, Q412_MAX, '0, Q412_MIN);
        plane_set[IDX_BOTTOM] = pack_plane('0, '0, Q412_MIN, Q412_MAX);
        plane_set[IDX_NEAR]   = pack_plane(Q412_MAX, '0, '0, Q412_MAX);
        plane_set[IDX_FAR]    = pack_plane('0, Q412_MIN, Q412_MAX, '0);
        load_planes(1'b0);
        push_box(mk_box(32767, 32767, 32767, 32767, 32767, 32767));
        push_box(mk_box(-32768, -32768, -32768, -32768, -32768, -32768));
        push_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
        push_box(mk_box(-86, -86, -86, -86, -86, -86));
        push_box(mk_box(32767, -32768, 32767, -32768, 32767, -32768));
        push_box(mk_box(0, 0, 0, 0, 0, 0));

        // random plane sets, each followed by a box stream
        while (sent < ITEM_GOAL) begin
            drain();
            bursts_on = (sent < CALM_FROM) && ($urandom_range(0, 3) != 0);
            live = $urandom_range(0, 6);
            for (int i = 0; i < REG_COUNT; i++)
                plane_set[i] = ($urandom_range(1, 6) <= live) ? rand_plane() : '0;
            load_planes($urandom_range(0, 3) == 0);
            n_items = (sent >= CALM_FROM) ? ITEM_GOAL - sent + 20 : $urandom_range(40, 80);
            repeat (n_items) push_box(rand_box());
        end
        drain();

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_frustum_aabb_cull_test OK");
        end else begin
            $display("tb_frustum_aabb_cull_test NOT OK");
        end
        $finish;
    end

endmodule
